// ===== rtl/cro_pkg.sv =====
// Shared types and codes of the contiguous ring outbox.
`timescale 1ns / 1ps

package cro_pkg;

    // Payload pointers and capacity are 17 bits so that a full 64 KiB space fits.
    localparam int PTR_W = 17;

    typedef enum logic [1:0] {
        FUNC_STAGE  = 2'd0,
        FUNC_READY  = 2'd1,
        FUNC_COMMIT = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_FROZEN   = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_LEN,
        ST_S_POS,
        ST_S_FIT,
        ST_S_WRAP,
        ST_S_BEFORE,
        ST_S_WRITE,
        ST_WALK,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] entry_lsn;
        logic [7:0]  entry_kind;
        logic [15:0] payload_length;
        logic [63:0] durable_mark;
        logic [6:0]  commit_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] write_offset;
        logic [6:0]  ready_count;
        logic [6:0]  pending_count;
    } out_word_t;

    typedef struct packed {
        logic [63:0] lsn;
        logic [15:0] offset;
    } slot_t;

endpackage

// ===== rtl/cro_slot_mem.sv =====
// Descriptor memory: one write port, one registered read port.
`timescale 1ns / 1ps

module cro_slot_mem
    import cro_pkg::*;
#(
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_t             wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_t             rd_data
);

    slot_t slot_ram_reg [2**ADDR_W];
    slot_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cro_cmp.sv =====
// Shared unsigned less-or-equal comparator used by the sequencer's compare steps.
`timescale 1ns / 1ps

module cro_cmp
    import cro_pkg::*;
(
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        a_le_b
);

    assign a_le_b = (op_a <= op_b);

endmodule

// ===== rtl/cro_ctrl.sv =====
// Sequencer and queue bookkeeping: stage placement, ready walk and commit.
`timescale 1ns / 1ps

module cro_ctrl
    import cro_pkg::*;
#(
    parameter int RING_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PTR_W-1:0]  cap,
    input  logic              frozen,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data,
    output logic              mem_wr_en,
    output logic [RING_W-1:0] mem_wr_addr,
    output slot_t             mem_wr_data,
    output logic [RING_W-1:0] mem_rd_addr,
    input  slot_t             mem_rd_data
);

    localparam int CNT_W = RING_W + 1;

    state_t             state_reg,   state_next;
    in_word_t           in_reg,      in_next;
    logic [PTR_W:0]     sum_reg,     sum_next;
    logic [RING_W-1:0]  head_reg,    head_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [PTR_W-1:0]   wp_reg,      wp_next;
    logic [CNT_W-1:0]   n_reg,       n_next;
    logic               wrap_reg,    wrap_next;
    logic [1:0]         status_reg,  status_next;
    logic [15:0]        offset_reg,  offset_next;
    out_word_t          out_reg,     out_next;
    logic               m_valid_reg, m_valid_next;

    logic [63:0]      cmp_a;
    logic [63:0]      cmp_b;
    logic             cmp_le;
    logic             full;
    logic             fits_here;
    logic             walk_go;
    logic             out_free;
    logic [CNT_W-1:0] release_n;

    cro_cmp u_cmp (
        .op_a   (cmp_a),
        .op_b   (cmp_b),
        .a_le_b (cmp_le)
    );

    // The ring is full only when the count reaches the ring size, its top bit.
    assign full      = count_reg[CNT_W-1];
    assign fits_here = cmp_le && !wp_reg[PTR_W-1];
    assign walk_go   = !frozen && (n_reg < count_reg) && cmp_le;
    assign out_free  = !m_valid_reg || m_ready;
    assign release_n = cmp_le ? CNT_W'(in_reg.commit_count) : count_reg;

    // Operand selection for the shared comparator, one question per step.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            ST_S_LEN: begin
                cmp_a = 64'(in_reg.payload_length);
                cmp_b = 64'(cap);
            end
            ST_S_POS: begin
                cmp_a = 64'(mem_rd_data.offset);
                cmp_b = 64'(wp_reg);
            end
            ST_S_FIT: begin
                cmp_a = 64'(sum_reg);
                cmp_b = 64'(cap);
            end
            ST_S_WRAP: begin
                cmp_a = 64'(in_reg.payload_length);
                cmp_b = 64'(mem_rd_data.offset);
            end
            ST_S_BEFORE: begin
                cmp_a = 64'(sum_reg);
                cmp_b = 64'(mem_rd_data.offset);
            end
            ST_WALK: begin
                cmp_a = mem_rd_data.lsn;
                cmp_b = in_reg.durable_mark;
            end
            ST_COMMIT: begin
                cmp_a = 64'(in_reg.commit_count);
                cmp_b = 64'(count_reg);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (func_t'(s_data.func))
                        FUNC_STAGE:  state_next = ST_S_LEN;
                        FUNC_READY:  state_next = ST_WALK;
                        FUNC_COMMIT: state_next = ST_COMMIT;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_S_LEN: begin
                if (full || !cmp_le) begin
                    state_next = ST_DONE;
                end else if (count_reg == '0) begin
                    state_next = ST_S_WRITE;
                end else begin
                    state_next = ST_S_POS;
                end
            end
            ST_S_POS:    state_next = cmp_le ? ST_S_FIT : ST_S_BEFORE;
            ST_S_FIT:    state_next = fits_here ? ST_S_WRITE : ST_S_WRAP;
            ST_S_WRAP:   state_next = cmp_le ? ST_S_WRITE : ST_DONE;
            ST_S_BEFORE: state_next = cmp_le ? ST_S_WRITE : ST_DONE;
            ST_S_WRITE:  state_next = ST_DONE;
            ST_WALK:     state_next = walk_go ? ST_WALK : ST_DONE;
            ST_COMMIT:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        in_next      = in_reg;
        sum_next     = sum_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        wp_next      = wp_reg;
        n_next       = n_reg;
        wrap_next    = wrap_reg;
        status_next  = status_reg;
        offset_next  = offset_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = head_reg + count_reg[RING_W-1:0];
        mem_wr_data.lsn    = in_reg.entry_lsn;
        mem_wr_data.offset = wrap_reg ? 16'd0 : wp_reg[15:0];
        // The read port tracks the oldest entry, or the next entry of the walk.
        mem_rd_addr  = (state_reg == ST_WALK) ?
                       head_reg + n_reg[RING_W-1:0] + RING_W'(1) : head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    sum_next    = {1'b0, wp_reg} + (PTR_W + 1)'(s_data.payload_length);
                    n_next      = '0;
                    wrap_next   = 1'b0;
                    status_next = STATUS_OK;
                    offset_next = '0;
                end
            end
            ST_S_LEN: begin
                if (full) begin
                    status_next = STATUS_EXHAUSTED;
                end else if (!cmp_le) begin
                    status_next = STATUS_RANGE;
                end else if (count_reg == '0) begin
                    wrap_next = 1'b1;
                end
            end
            ST_S_FIT: begin
                if (!fits_here) begin
                    wrap_next = 1'b1;
                end
            end
            ST_S_WRAP, ST_S_BEFORE: begin
                if (!cmp_le) begin
                    status_next = STATUS_EXHAUSTED;
                end
            end
            ST_S_WRITE: begin
                mem_wr_en   = 1'b1;
                offset_next = mem_wr_data.offset;
                wp_next     = wrap_reg ? PTR_W'(in_reg.payload_length) : sum_reg[PTR_W-1:0];
                count_next  = count_reg + CNT_W'(1);
            end
            ST_WALK: begin
                if (walk_go) begin
                    n_next = n_reg + CNT_W'(1);
                end
            end
            ST_COMMIT: begin
                head_next  = head_reg + release_n[RING_W-1:0];
                count_next = count_reg - release_n;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_next.status        = status_reg;
                    out_next.write_offset  = offset_reg;
                    out_next.ready_count   = 7'(n_reg);
                    out_next.pending_count = 7'(count_reg);
                    m_valid_next           = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        sum_reg    <= sum_next;
        n_reg      <= n_next;
        wrap_reg   <= wrap_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/contiguous_ring_outbox_core.sv =====
// Top level of the contiguous ring outbox: configuration registers and the sequencer.
`timescale 1ns / 1ps

// Descriptor queue over a circular payload space that never splits a payload. Each
// input word is one operation: stage (place a payload and enqueue its descriptor),
// ready query (count leading entries at or below a durable mark, zero while frozen)
// or commit (release the oldest entries). One word is processed at a time by a
// sequencer around a single shared comparator and a descriptor memory with a
// registered read port. The ready walk reads one descriptor per cycle from the
// memory. A result held back by the consumer stalls the sequencer before it returns
// to idle. A new word is accepted as soon as the sequencer is idle, even while the
// previous result still waits in the output register. Configuration writes are
// always accepted.
module contiguous_ring_outbox_core
    import cro_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int BUF_BYTES = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [PTR_W-1:0] cfg_data
);

    localparam int RING_W = (SLOTS <= 16) ? 4 : $clog2(SLOTS);
    localparam logic [PTR_W-1:0] CAP_MAX = PTR_W'(BUF_BYTES);

    logic [PTR_W-1:0]  cap_reg;
    logic              frozen_reg;
    logic              mem_wr_en;
    logic [RING_W-1:0] mem_wr_addr;
    slot_t             mem_wr_data;
    logic [RING_W-1:0] mem_rd_addr;
    slot_t             mem_rd_data;

    assign cfg_ready = 1'b1;

    // Capacity is saturated to the physical space when it is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_MAX;
            frozen_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg <= (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;
                CFG_FROZEN:   frozen_reg <= cfg_data[0];
                default: begin
                    cap_reg <= cap_reg;
                end
            endcase
        end
    end

    cro_ctrl #(
        .RING_W (RING_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cap         (cap_reg),
        .frozen      (frozen_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cro_slot_mem #(
        .ADDR_W (RING_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/cro_checker.sv =====
// Port-level checks of the contiguous ring outbox and their binding.
`timescale 1ns / 1ps

module cro_checker
    import cro_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input in_word_t         s_data,
    input logic             m_valid,
    input logic             m_ready,
    input out_word_t        m_data,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [1:0]       cfg_index,
    input logic [PTR_W-1:0] cfg_data
);

    // A result waiting for the consumer must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is in progress");

    // A failed stage reports no placement and no ready count.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_EXHAUSTED || m_data.status == STATUS_RANGE)
        |-> m_data.write_offset == '0 && m_data.ready_count == '0)
        else $error("failed stage carries offset or ready count");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind contiguous_ring_outbox_core cro_checker u_cro_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ===== sim/outbox_check_pkg.sv =====
// Scoreboard for the contiguous ring outbox: placement predictor and result checks.
`timescale 1ns / 1ps

package outbox_check_pkg;
    import cro_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int SPACE_LIMIT = 65536;

    class outbox_scoreboard;
        logic [63:0] lsn_ring [RING_DEPTH];
        int unsigned offset_ring [RING_DEPTH];
        int unsigned head;
        int unsigned pending;
        int unsigned write_ptr;
        int unsigned capacity;
        bit          frozen;
        out_word_t   expected_words [$];
        int unsigned mismatches;

        function new();
            head       = 0;
            pending    = 0;
            write_ptr  = 0;
            capacity   = SPACE_LIMIT;
            frozen     = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [16:0] value);
            if (idx == CFG_CAPACITY) begin
                capacity = value;
            end else if (idx == CFG_FROZEN) begin
                frozen = value[0];
            end
        endfunction

        function out_word_t predict_outcome(in_word_t w);
            out_word_t   r;
            int unsigned usable;
            int unsigned len;
            int unsigned place;
            int unsigned oldest;
            int unsigned slot;
            int unsigned n;
            r = '0;
            case (w.func)
                FUNC_STAGE: begin
                    usable = (capacity > SPACE_LIMIT) ? SPACE_LIMIT : capacity;
                    len    = w.payload_length;
                    place  = write_ptr;
                    if (pending >= RING_DEPTH) begin
                        r.status = STATUS_EXHAUSTED;
                    end else if (len > usable) begin
                        r.status = STATUS_RANGE;
                    end else begin
                        if (pending == 0) begin
                            place = 0;
                        end else begin
                            oldest = offset_ring[head];
                            if (write_ptr >= oldest) begin
                                // Past the oldest payload: wrap to zero if it does not
                                // fit before the end, as long as it stays below the oldest.
                                if (write_ptr + len > usable || write_ptr > 65535) begin
                                    if (len > oldest) begin
                                        r.status = STATUS_EXHAUSTED;
                                    end else begin
                                        place = 0;
                                    end
                                end
                            end else if (write_ptr + len > oldest) begin
                                r.status = STATUS_EXHAUSTED;
                            end
                        end
                        if (r.status == STATUS_OK) begin
                            slot              = (head + pending) % RING_DEPTH;
                            lsn_ring[slot]    = w.entry_lsn;
                            offset_ring[slot] = place & 32'hFFFF;
                            write_ptr         = (place + len) & 32'h1FFFF;
                            pending           = pending + 1;
                            r.write_offset    = place[15:0];
                        end
                    end
                end
                FUNC_READY: begin
                    n = 0;
                    if (!frozen) begin
                        while (n < pending &&
                               lsn_ring[(head + n) % RING_DEPTH] <= w.durable_mark) begin
                            n = n + 1;
                        end
                    end
                    r.ready_count = n[6:0];
                end
                FUNC_COMMIT: begin
                    n       = (w.commit_count > pending) ? pending : w.commit_count;
                    head    = (head + n) % RING_DEPTH;
                    pending = pending - n;
                end
                default: begin
                end
            endcase
            r.pending_count = pending[6:0];
            return r;
        endfunction

        function void note_word(in_word_t w);
            expected_words.push_back(predict_outcome(w));
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0) begin
                $error("result word arrived with no expected word waiting");
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.write_offset !== want.write_offset) begin
                $error("write_offset: expected %0d, got %0d",
                       want.write_offset, got.write_offset);
                mismatches++;
            end
            if (got.ready_count !== want.ready_count) begin
                $error("ready_count: expected %0d, got %0d", want.ready_count, got.ready_count);
                mismatches++;
            end
            if (got.pending_count !== want.pending_count) begin
                $error("pending_count: expected %0d, got %0d",
                       want.pending_count, got.pending_count);
                mismatches++;
            end
        endfunction

        function bit waiting();
            return expected_words.size() != 0;
        endfunction

        function bit clean();
            return mismatches == 0 && expected_words.size() == 0;
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// Testbench top for the contiguous ring outbox core: stimulus, handshakes and watchdog.
`timescale 1ns / 1ps

module tb_top;
    import cro_pkg::*;
    import outbox_check_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 120;
    localparam int STALL_LIMIT = 3000;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_word_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_word_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_CAPACITY;
    logic [PTR_W-1:0] cfg_data  = '0;

    outbox_scoreboard sb;
    bit               steady_stretch = 1'b0;
    int unsigned      cap_now = SPACE_LIMIT;
    logic [63:0]      next_lsn = 64'd16;

    // Capacities cover zero, tiny, mid, exact full space and saturated values.
    int unsigned phase_cap  [PHASES] = '{131071, 65536, 1000, 256, 0, 4096,
                                         65536, 300, 131071, 20000, 65535, 1};
    int unsigned phase_span [PHASES] = '{64, 20000, 300, 80, 0, 1500,
                                         65535, 100, 2000, 6000, 30000, 1};
    int unsigned phase_fill [PHASES] = '{85, 55, 60, 55, 50, 60,
                                         55, 85, 50, 60, 55, 60};

    contiguous_ring_outbox_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit take_gap();
        return !steady_stretch && ($urandom_range(0, 99) < 28);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_data);
        end
        m_ready <= !take_gap();
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic in_word_t op_word(func_t f, logic [63:0] lsn, logic [7:0] kind,
                                         logic [15:0] len, logic [63:0] durable,
                                         logic [6:0] cnt);
        in_word_t w;
        w.func           = f;
        w.entry_lsn      = lsn;
        w.entry_kind     = kind;
        w.payload_length = len;
        w.durable_mark   = durable;
        w.commit_count   = cnt;
        return w;
    endfunction

    function automatic in_word_t random_word(int unsigned fill_pct, int unsigned span);
        in_word_t    w;
        int unsigned roll;
        int          len;
        roll = $urandom_range(0, 99);
        if (roll < fill_pct) begin
            w.func = FUNC_STAGE;
        end else if (roll < fill_pct + (100 - fill_pct) / 2) begin
            w.func = FUNC_READY;
        end else if (roll < 97) begin
            w.func = FUNC_COMMIT;
        end else begin
            w.func = FUNC_NOP;
        end

        if ($urandom_range(0, 99) < 85) begin
            w.entry_lsn = next_lsn;
            next_lsn    = next_lsn + $urandom_range(1, 3);
        end else begin
            w.entry_lsn = {$urandom, $urandom};
        end
        w.entry_kind = 8'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            len = $urandom_range(0, span);
        end else if (roll < 75) begin
            // Lengths right at the capacity edge.
            len = int'(cap_now) - int'($urandom_range(0, 2)) + int'($urandom_range(0, 1));
        end else if (roll < 85) begin
            len = 0;
        end else begin
            len = $urandom_range(0, 65535);
        end
        if (len < 0) len = 0;
        if (len > 65535) len = 65535;
        w.payload_length = len[15:0];

        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            w.durable_mark = next_lsn - $urandom_range(0, 40);
        end else if (roll < 80) begin
            w.durable_mark = '1;
        end else if (roll < 90) begin
            w.durable_mark = '0;
        end else begin
            w.durable_mark = {$urandom, $urandom};
        end

        if ($urandom_range(0, 99) < 80) begin
            w.commit_count = 7'($urandom_range(1, 3));
        end else begin
            w.commit_count = 7'($urandom_range(0, 127));
        end
        return w;
    endfunction

    // Valid stays high from one word to the next unless a gap is rolled.
    task automatic send_word(in_word_t w);
        if (take_gap()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (take_gap());
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.waiting());
    endtask

    task automatic write_register(logic [1:0] idx, logic [PTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
    endtask

    task automatic configure(int unsigned cap, bit frz);
        write_register(CFG_CAPACITY, cap[PTR_W-1:0]);
        write_register(CFG_FROZEN, {{(PTR_W-1){1'b0}}, frz});
        cfg_valid <= 1'b0;
        cap_now = (cap > SPACE_LIMIT) ? SPACE_LIMIT : cap;
    endtask

    initial begin
        bit frz;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: full space, not frozen.
        send_word(op_word(FUNC_READY, 0, 0, 0, 0, 0));
        send_word(op_word(FUNC_STAGE, 0, 8'h00, 16'hFFFF, 0, 0));
        send_word(op_word(FUNC_STAGE, 1, 8'hFF, 1, 0, 0));
        // Zero-length payload with the pointer at the very top wraps to zero.
        send_word(op_word(FUNC_STAGE, 2, 8'h5A, 0, 0, 0));
        send_word(op_word(FUNC_READY, 0, 0, 0, '1, 0));
        send_word(op_word(FUNC_READY, 0, 0, 0, 0, 0));
        send_word(op_word(FUNC_COMMIT, 0, 0, 0, 0, 7'h7F));
        send_word(op_word(FUNC_NOP, '1, 8'hFF, 16'hFFFF, '1, 7'h7F));
        send_word(op_word(FUNC_STAGE, '1, 8'hA5, 16'h5A5A, 0, 0));

        drain_results();
        configure(1000, 1'b1);
        send_word(op_word(FUNC_STAGE, 3, 1, 1001, 0, 0));
        send_word(op_word(FUNC_READY, 0, 0, 0, '1, 0));
        send_word(op_word(FUNC_COMMIT, 0, 0, 0, 0, 64));
        send_word(op_word(FUNC_STAGE, 4, 2, 400, 0, 0));
        send_word(op_word(FUNC_STAGE, 5, 3, 400, 0, 0));
        send_word(op_word(FUNC_STAGE, 6, 4, 300, 0, 0));
        send_word(op_word(FUNC_COMMIT, 0, 0, 0, 0, 1));
        send_word(op_word(FUNC_STAGE, 7, 5, 300, 0, 0));
        send_word(op_word(FUNC_STAGE, 8, 6, 200, 0, 0));
        send_word(op_word(FUNC_STAGE, 9, 7, 100, 0, 0));
        send_word(op_word(FUNC_STAGE, 10, 8, 1000, 0, 0));

        drain_results();
        configure(65537, 1'b0);
        send_word(op_word(FUNC_COMMIT, 0, 0, 0, 0, 0));
        send_word(op_word(FUNC_READY, 0, 0, 0, 64'd7, 0));
        send_word(op_word(FUNC_COMMIT, 0, 0, 0, 0, 64));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            frz = (p == 1) ? 1'b1 : (p == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
            configure(phase_cap[p], frz);
            if ($urandom_range(0, 1) != 0) begin
                next_lsn = {$urandom, $urandom};
            end
            steady_stretch = (p == 3 || p == 4);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(random_word(phase_fill[p], phase_span[p]));
                if (p == 6 && i == PHASE_WORDS / 2) begin
                    drain_results();
                end
            end
        end
        steady_stretch = 1'b0;

        drain_results();
        repeat (80) @(posedge aclk);
        if (sb.clean()) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== contiguous_ring_outbox_core.f =====
rtl/cro_pkg.sv
rtl/cro_slot_mem.sv
rtl/cro_cmp.sv
rtl/cro_ctrl.sv
rtl/contiguous_ring_outbox_core.sv
rtl/cro_checker.sv
sim/outbox_check_pkg.sv
sim/tb_top.sv
